FILE: hw/rtl/ccpc_pkg.sv
// Shared constants, types and action codes for the character-cell priority compositor.
// Depends on nothing; the top level and the register file refer to it by scoped names, and the testbench imports it.

package ccpc_pkg;

  // Frame store geometry: cells are addressed row * MAX_COLUMNS + column.
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  // Widths of the visible-size limits (they must hold MAX_COLUMNS and MAX_ROWS themselves).
  localparam int VIS_W_BITS = 9;
  localparam int VIS_H_BITS = 8;

  // Action codes carried by an input beat; the unused code behaves as a read.
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] RESET_WIDTH  = 8'd80;
  localparam logic [6:0] RESET_HEIGHT = 7'd25;

  typedef struct packed {
    logic [7:0] width;
    logic [6:0] height;
  } ccpc_cfg_t;

  typedef struct packed {
    logic [7:0]  glyph;
    logic [15:0] color;
    logic [15:0] prio;
  } ccpc_cell_t;

  localparam int CELL_W = $bits(ccpc_cell_t);

  // A cleared cell: a space, colour zero and priority minus one.
  localparam ccpc_cell_t BLANK_CELL = '{glyph: 8'd32, color: 16'd0, prio: 16'hFFFF};

endpackage

FILE: hw/rtl/ccpc_intf.sv
// Valid/ready channel interfaces for the compositor's item and result streams.
// Depends on nothing but plain logic types.

interface ccpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [8:0]  column;
  logic signed [7:0]  row;
  logic [7:0]         glyph;
  logic [15:0]        color;
  logic signed [15:0] priority_req;

  modport source (output valid, action, column, row, glyph, color, priority_req,
                  input ready);
  modport sink   (input valid, action, column, row, glyph, color, priority_req,
                  output ready);
endinterface

interface ccpc_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         read_glyph;
  logic [15:0]        read_color;
  logic signed [15:0] read_priority;
  logic               was_written;
  logic               off_screen;

  modport source (output valid, read_glyph, read_color, read_priority, was_written,
                  off_screen, input ready);
  modport sink   (input valid, read_glyph, read_color, read_priority, was_written,
                  off_screen, output ready);
endinterface

FILE: hw/rtl/ccpc_cell_ram.sv
// Generic single-write, single-read synchronous RAM holding the character cells.
// Self-contained; read data is registered and holds when no read is issued.

module ccpc_cell_ram #(
  parameter int DEPTH  = 8192,
  parameter int WIDTH  = 40,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/ccpc_cfg_regs.sv
// APB-style register file holding the configured screen width and height.
// Depends on ccpc_pkg for the register indexes, reset values and the config struct.

module ccpc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ccpc_pkg::ccpc_cfg_t cfg
);

  ccpc_pkg::ccpc_cfg_t cfg_r;
  ccpc_pkg::ccpc_cfg_t cfg_nxt;
  logic                wr_en;

  // Byte lanes within a word are ignored, so bit 2 selects the register.
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        ccpc_pkg::REG_WIDTH:  cfg_nxt.width  = pwdata[7:0];
        ccpc_pkg::REG_HEIGHT: cfg_nxt.height = pwdata[6:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= ccpc_pkg::RESET_WIDTH;
      cfg_r.height <= ccpc_pkg::RESET_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      ccpc_pkg::REG_WIDTH:  prdata = {24'd0, cfg_r.width};
      ccpc_pkg::REG_HEIGHT: prdata = {25'd0, cfg_r.height};
      default:              prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

FILE: hw/rtl/char_cell_priority_compositor.sv
// Top level of the character-cell priority compositor: control sequencer around the cell RAM.
// Depends on ccpc_pkg, ccpc_intf (channel interfaces), ccpc_cell_ram and ccpc_cfg_regs.
//
//   Port        | Direction | Protocol         | Carries
//   ------------+-----------+------------------+----------------------------------------------
//   in_beat     | sink      | valid/ready      | action, column, row, glyph, colour, priority
//   out_beat    | source    | valid/ready      | cell contents, was_written, off_screen
//   psel..prdata| slave     | APB-style, 32 b  | screen_width at 0x0, screen_height at 0x4
//
// Each item is accepted in the idle state, where the accept issues the RAM read; the lookup
// state then compares priorities, writes the cell back and loads the output register. The cell
// RAM's single read-modify-write path means that only one item is in flight at a time.
// A clear item, and reset itself, run a sweep that writes a blank into every one of the
// CELL_COUNT cells; no item is accepted during the sweep, but configuration writes are taken
// as ever. A stalled result holds in the output register and the item waiting behind it
// keeps its read data until the register frees.

module char_cell_priority_compositor (
  input  logic                clk,
  input  logic                rst_n,
  ccpc_in_if.sink             in_beat,
  ccpc_out_if.source          out_beat,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  localparam int ADDR_W = ccpc_pkg::ADDR_W;
  localparam int VW     = ccpc_pkg::VIS_W_BITS;
  localparam int VH     = ccpc_pkg::VIS_H_BITS;

  ccpc_pkg::ccpc_cfg_t cfg;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   sweep_addr_r, sweep_addr_nxt;

  // Item captured at the accept beat.
  logic [1:0]          action_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                off_r;
  logic [7:0]          glyph_r;
  logic [15:0]         color_r;
  logic [15:0]         prio_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  ccpc_pkg::ccpc_cell_t out_cell_r, out_cell_nxt;
  logic                out_written_r, out_written_nxt;
  logic                out_off_r, out_off_nxt;

  logic                in_accept;
  logic                out_free;
  logic [VW-1:0]       vis_w;
  logic [VH-1:0]       vis_h;
  logic                off_now;
  logic [ADDR_W-1:0]   addr_now;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  ccpc_pkg::ccpc_cell_t ram_wdata;
  logic                ram_re;
  ccpc_pkg::ccpc_cell_t rd_cell;
  logic [ccpc_pkg::CELL_W-1:0] rd_bits;

  logic                lookup_done;
  logic                draw_win;

  ccpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Visible size is the register clamped to the store's geometry.
  assign vis_w = ({1'b0, cfg.width} >= VW'(ccpc_pkg::MAX_COLUMNS)) ?
                 VW'(ccpc_pkg::MAX_COLUMNS) : {1'b0, cfg.width};
  assign vis_h = ({1'b0, cfg.height} >= VH'(ccpc_pkg::MAX_ROWS)) ?
                 VH'(ccpc_pkg::MAX_ROWS) : {1'b0, cfg.height};

  // A negative coordinate has its sign bit set; otherwise the low bits are the magnitude.
  assign off_now = in_beat.column[8] || in_beat.row[7] ||
                   ({1'b0, in_beat.column[7:0]} >= vis_w) ||
                   ({1'b0, in_beat.row[6:0]} >= vis_h);
  assign addr_now = ADDR_W'(ADDR_W'(in_beat.row[6:0]) * ADDR_W'(ccpc_pkg::MAX_COLUMNS)) +
                    ADDR_W'(in_beat.column[7:0]);

  assign in_beat.ready = (state_r == ST_IDLE);
  assign in_accept     = in_beat.valid && in_beat.ready;
  assign out_free      = !out_valid_r || out_beat.ready;

  assign ram_re    = in_accept && !off_now;
  assign rd_cell   = ccpc_pkg::ccpc_cell_t'(rd_bits);

  // An equal priority overwrites; only a strictly higher stored priority blocks the draw.
  assign draw_win    = (action_r == ccpc_pkg::ACT_DRAW) && !off_r &&
                       !($signed(rd_cell.prio) > $signed(prio_r));
  assign lookup_done = (state_r == ST_LOOKUP) && out_free;

  always_comb begin
    if (state_r == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_r;
      ram_wdata = ccpc_pkg::BLANK_CELL;
    end else begin
      ram_we    = lookup_done && draw_win;
      ram_waddr = addr_r;
      ram_wdata = '{glyph: glyph_r, color: color_r, prio: prio_r};
    end
  end

  ccpc_cell_ram #(
    .DEPTH  (ccpc_pkg::CELL_COUNT),
    .WIDTH  (ccpc_pkg::CELL_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_now),
    .rdata (rd_bits)
  );

  // Sequencer: next state, sweep counter and the output register.
  always_comb begin
    state_nxt       = state_r;
    sweep_addr_nxt  = sweep_addr_r;
    out_valid_nxt   = out_valid_r && !out_beat.ready;
    out_cell_nxt    = out_cell_r;
    out_written_nxt = out_written_r;
    out_off_nxt     = out_off_r;

    unique case (state_r)
      ST_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
        if (sweep_addr_r == ADDR_W'(ccpc_pkg::CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_written_nxt = draw_win;
          out_off_nxt     = off_r;
          if (off_r) begin
            out_cell_nxt = '0;
          end else if (action_r == ccpc_pkg::ACT_CLEAR) begin
            out_cell_nxt = ccpc_pkg::BLANK_CELL;
          end else if (draw_win) begin
            out_cell_nxt = ram_wdata;
          end else begin
            out_cell_nxt = rd_cell;
          end
          if (action_r == ccpc_pkg::ACT_CLEAR) begin
            state_nxt      = ST_SWEEP;
            sweep_addr_nxt = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_addr_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_cell_r    <= out_cell_nxt;
    out_written_r <= out_written_nxt;
    out_off_r     <= out_off_nxt;
    if (in_accept) begin
      action_r <= in_beat.action;
      addr_r   <= addr_now;
      off_r    <= off_now;
      glyph_r  <= in_beat.glyph;
      color_r  <= in_beat.color;
      prio_r   <= in_beat.priority_req;
    end
  end

  assign out_beat.valid         = out_valid_r;
  assign out_beat.read_glyph    = out_cell_r.glyph;
  assign out_beat.read_color    = out_cell_r.color;
  assign out_beat.read_priority = out_cell_r.prio;
  assign out_beat.was_written   = out_written_r;
  assign out_beat.off_screen    = out_off_r;

  // Outside the sweep the RAM is written only by an on-screen draw.
  a_write_only_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ST_SWEEP) |-> (action_r == ccpc_pkg::ACT_DRAW && !off_r))
    else $error("cell RAM written by an item that is not an on-screen draw");

  // An off-screen cell is never reported as written.
  a_written_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_beat.was_written && out_beat.off_screen))
    else $error("result reports a write to an off-screen cell");

  // An accepted item moves to the lookup state in the cycle after the accept beat.
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_LOOKUP))
    else $error("accepted item did not move to the lookup cycle");

  // A finished clear restarts the sweep from the first cell.
  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (lookup_done && action_r == ccpc_pkg::ACT_CLEAR) |=>
      (state_r == ST_SWEEP && sweep_addr_r == '0))
    else $error("clear item did not start a sweep at cell zero");

  // Completing a lookup always loads a result.
  a_lookup_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_done |=> out_valid_r)
    else $error("lookup finished without loading a result");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the character-cell priority compositor.
// Depends on ccpc_pkg, the ccpc_in_if/ccpc_out_if channel interfaces and the block's top level.

module tb_top;
  import ccpc_pkg::*;

  // The fourth action code has no name in the package; the block treats it as a read.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // A cleared frame takes a full sweep of the store, so the watchdog must outlast several
  // of those plus the longest receiver hold-off before it calls the run stuck.
  localparam int STALL_LIMIT    = 40000;
  localparam int HOLD_OFF_BEATS = 400;
  localparam int DRAIN_TAIL     = 16;
  localparam int MAX_CLEARS     = 6;

  typedef struct {
    logic [1:0]         action;
    logic signed [8:0]  column;
    logic signed [7:0]  row;
    logic [7:0]         glyph;
    logic [15:0]        color;
    logic signed [15:0] priority_req;
  } draw_beat_t;

  typedef struct {
    logic [7:0]         glyph;
    logic [15:0]        color;
    logic signed [15:0] prio;
    logic               was_written;
    logic               off_screen;
  } cell_report_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ccpc_in_if  in_beat ();
  ccpc_out_if out_beat ();

  char_cell_priority_compositor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .out_beat (out_beat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Our own copy of the frame store, kept in step with every accepted beat.
  logic [7:0]         glyph_plane [CELL_COUNT];
  logic [15:0]        color_plane [CELL_COUNT];
  logic signed [15:0] prio_plane  [CELL_COUNT];

  // Screen size as last written; it only changes while nothing is in flight.
  int cur_width;
  int cur_height;

  draw_beat_t   pending_beats[$];
  cell_report_t expected_reports[$];
  draw_beat_t   offered_beat;

  int   mismatch_count;
  int   clears_left;
  int   stuck_cycles;
  int   hold_left;
  logic steady_phase;
  logic hold_go;

  always #6 clk = ~clk;

  // Works out the result of one beat and applies its effect to the local frame store.
  // An off-screen beat reports zeros and touches nothing unless it is a clear; a clear blanks
  // the whole store, including cells beyond the visible area.
  function automatic cell_report_t composite_cell(draw_beat_t b);
    int           vis_w;
    int           vis_h;
    int           col;
    int           rw;
    int           addr;
    logic         off;
    cell_report_t rep;
    vis_w = (cur_width < MAX_COLUMNS) ? cur_width : MAX_COLUMNS;
    vis_h = (cur_height < MAX_ROWS) ? cur_height : MAX_ROWS;
    col   = b.column;
    rw    = b.row;
    off   = (col < 0) || (rw < 0) || (col >= vis_w) || (rw >= vis_h);
    addr  = off ? 0 : rw * MAX_COLUMNS + col;
    rep   = '{glyph: 8'd0, color: 16'd0, prio: 16'sd0, was_written: 1'b0, off_screen: off};
    if (b.action == ACT_CLEAR) begin
      for (int i = 0; i < CELL_COUNT; i++) begin
        glyph_plane[i] = BLANK_CELL.glyph;
        color_plane[i] = BLANK_CELL.color;
        prio_plane[i]  = BLANK_CELL.prio;
      end
    end else if (b.action == ACT_DRAW && !off) begin
      // A stored priority strictly above the request keeps the cell; a tie overwrites.
      if (!(prio_plane[addr] > b.priority_req)) begin
        glyph_plane[addr] = b.glyph;
        color_plane[addr] = b.color;
        prio_plane[addr]  = b.priority_req;
        rep.was_written   = 1'b1;
      end
    end
    if (!off) begin
      rep.glyph = glyph_plane[addr];
      rep.color = color_plane[addr];
      rep.prio  = prio_plane[addr];
    end
    return rep;
  endfunction

  task automatic push_beat(logic [1:0] act, int col, int rw, int gl, int colr, int pr);
    draw_beat_t b;
    b.action       = act;
    b.column       = col;
    b.row          = rw;
    b.glyph        = gl;
    b.color        = colr;
    b.priority_req = pr;
    pending_beats.push_back(b);
  endtask

  // Random beats are mostly draws and reads packed into a small corner of the screen, so
  // that priorities collide and reads land on drawn cells. The rest sits on the screen
  // edges or anywhere in the full signed range of the fields.
  task automatic push_random_beat();
    int         pick;
    int         place;
    int         span_c;
    int         span_r;
    int         col;
    int         rw;
    int         pr;
    logic [1:0] act;
    pick = $urandom_range(0, 99);
    if (pick < 1 && clears_left > 0) begin
      act = ACT_CLEAR;
      clears_left--;
    end else if (pick < 56) begin
      act = ACT_DRAW;
    end else if (pick < 96) begin
      act = ACT_READ;
    end else begin
      act = ACT_SPARE;
    end
    span_c = (cur_width > 12) ? 12 : cur_width + 2;
    span_r = (cur_height > 6) ? 6 : cur_height + 2;
    place  = $urandom_range(0, 9);
    if (place == 0) begin
      col = $urandom_range(0, 511);
      rw  = $urandom_range(0, 255);
    end else if (place == 1) begin
      col = ((cur_width < MAX_COLUMNS) ? cur_width : MAX_COLUMNS) - 1 + $urandom_range(0, 2);
      rw  = ((cur_height < MAX_ROWS) ? cur_height : MAX_ROWS) - 1 + $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) col = -1;
    end else begin
      col = $urandom_range(0, span_c - 1);
      rw  = $urandom_range(0, span_r - 1);
    end
    if ($urandom_range(0, 1) == 0) pr = $urandom_range(0, 8) - 4;
    else pr = $urandom_range(0, 65535);
    push_beat(act, col, rw, $urandom_range(0, 255), $urandom_range(0, 65535), pr);
  endtask

  // Settles on the falling edge, when every beat and result of the rising edge has landed.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || expected_reports.size() != 0 || in_beat.valid);
  endtask

  // Two-phase register write: setup cycle, then access until the port reports ready.
  task automatic cfg_write(logic idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One phase: drain, retune the screen size, then queue a batch of random beats. The
  // steady flag switches idling off on both sides; the squeeze flag starts the long
  // receiver hold-off while the sender keeps offering beats.
  task automatic run_phase(int w, int h, int count, logic steady, logic squeeze);
    wait_drained();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    @(negedge clk);
    cur_width    = w;
    cur_height   = h;
    steady_phase <= steady;
    for (int i = 0; i < count; i++) push_random_beat();
    if (squeeze) begin
      hold_go <= 1'b1;
      @(negedge clk);
      hold_go <= 1'b0;
    end
  endtask

  // Driver: at each rising edge the beat on the bus is either taken, and then predicted,
  // or held. A fresh beat is only put up once the bus is free, so valid never drops
  // under a beat that has not been accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_beat.valid <= 1'b0;
    end else begin
      if (in_beat.valid && in_beat.ready) begin
        expected_reports.push_back(composite_cell(offered_beat));
      end
      if (!in_beat.valid || in_beat.ready) begin
        if (pending_beats.size() != 0 && (steady_phase || $urandom_range(0, 99) >= 14)) begin
          offered_beat         = pending_beats.pop_front();
          in_beat.valid        <= 1'b1;
          in_beat.action       <= offered_beat.action;
          in_beat.column       <= offered_beat.column;
          in_beat.row          <= offered_beat.row;
          in_beat.glyph        <= offered_beat.glyph;
          in_beat.color        <= offered_beat.color;
          in_beat.priority_req <= offered_beat.priority_req;
        end else begin
          in_beat.valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Monitor: every result beat is matched against the oldest prediction, field by field.
  always @(posedge clk) begin
    cell_report_t want;
    if (!rst_n) begin
      out_beat.ready <= 1'b0;
    end else begin
      if (out_beat.valid && out_beat.ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected, expected none, actual glyph %0d",
                   $time, out_beat.read_glyph);
        end else begin
          want = expected_reports.pop_front();
          flag_field("read_glyph", want.glyph, out_beat.read_glyph);
          flag_field("read_color", want.color, out_beat.read_color);
          flag_field("read_priority", want.prio, out_beat.read_priority);
          flag_field("was_written", want.was_written, out_beat.was_written);
          flag_field("off_screen", want.off_screen, out_beat.off_screen);
        end
      end
      out_beat.ready <= (hold_left == 0) && (steady_phase || $urandom_range(0, 99) >= 14);
    end
  end

  // Long receiver hold-off, counted here so that the main sequence is free to carry on.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_OFF_BEATS;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: a run of cycles without any beat on either channel means the block is stuck.
  always @(posedge clk) begin
    if ((in_beat.valid && in_beat.ready) || (out_beat.valid && out_beat.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("FAIL char_cell_priority_compositor");
        $finish;
      end
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_beat.valid        = 1'b0;
    in_beat.action       = ACT_READ;
    in_beat.column       = '0;
    in_beat.row          = '0;
    in_beat.glyph        = '0;
    in_beat.color        = '0;
    in_beat.priority_req = '0;
    out_beat.ready       = 1'b0;
    mismatch_count       = 0;
    clears_left          = MAX_CLEARS;
    stuck_cycles         = 0;
    hold_left            = 0;
    hold_go              = 1'b0;
    steady_phase         = 1'b0;
    cur_width            = RESET_WIDTH;
    cur_height           = RESET_HEIGHT;
    for (int i = 0; i < CELL_COUNT; i++) begin
      glyph_plane[i] = BLANK_CELL.glyph;
      color_plane[i] = BLANK_CELL.color;
      prio_plane[i]  = BLANK_CELL.prio;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset screen size of 80 by 25. The block sweeps the store
    // after reset, so these simply wait at the input until it is ready.
    @(negedge clk);
    push_beat(ACT_READ, 0, 0, 0, 0, 0);                  // untouched cell reads blank
    push_beat(ACT_DRAW, 0, 0, 65, 16'hFFFF, 0);           // beats the blank priority
    push_beat(ACT_DRAW, 0, 0, 66, 16'h1234, 0);           // equal priority overwrites
    push_beat(ACT_DRAW, 0, 0, 67, 16'h5555, -1);          // lower priority is dropped
    push_beat(ACT_READ, 0, 0, 0, 0, 0);
    push_beat(ACT_DRAW, 79, 24, 255, 16'hFFFF, 32767);    // far corner, top priority
    push_beat(ACT_DRAW, 79, 24, 0, 16'h0000, 32767);      // tie at the top still wins
    push_beat(ACT_DRAW, 78, 24, 1, 16'hAAAA, -32768);     // loses to the blank priority
    push_beat(ACT_DRAW, 78, 24, 2, 16'h00FF, -1);         // ties the blank priority
    push_beat(ACT_DRAW, 80, 0, 3, 16'h0F0F, 100);         // one column past the edge
    push_beat(ACT_DRAW, 0, 25, 4, 16'hF0F0, 100);         // one row past the edge
    push_beat(ACT_READ, -1, 0, 0, 0, 0);
    push_beat(ACT_READ, 0, -1, 0, 0, 0);
    push_beat(ACT_READ, -256, -128, 255, 16'hFFFF, -1);
    push_beat(ACT_READ, 255, 127, 255, 16'hFFFF, 32767);
    push_beat(ACT_SPARE, 79, 24, 0, 0, 0);                // spare code reads the cell
    push_beat(ACT_CLEAR, 79, 24, 9, 16'h9999, 9);         // reports the blanked cell
    push_beat(ACT_READ, 0, 0, 0, 0, 0);
    push_beat(ACT_CLEAR, -5, -5, 0, 0, 0);                // clear addressed off screen
    push_beat(ACT_DRAW, 10, 10, 88, 16'h8001, 5);
    push_beat(ACT_SPARE, 10, 10, 0, 0, 0);

    // Random phases across the range of screen sizes: the full store, a single cell,
    // sizes above the store that clamp, a zero size that puts every cell off screen,
    // an odd size with the long hold-off, and back to the reset size.
    run_phase(128, 64, 150, 1'b0, 1'b0);
    run_phase(1, 1, 60, 1'b0, 1'b0);
    run_phase(200, 100, 120, 1'b1, 1'b0);
    run_phase(0, 0, 20, 1'b0, 1'b0);
    run_phase(37, 9, 150, 1'b0, 1'b1);
    run_phase(80, 25, 100, 1'b0, 1'b0);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("PASS char_cell_priority_compositor");
    end else begin
      $display("FAIL char_cell_priority_compositor");
    end
    $finish;
  end

endmodule
